[design/cfge_pkg.sv]
// Shared types, register codes and the quarter-sine table function
// for the clip fade/gain envelope block. No dependencies.
package cfge_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FADE_IN_LEN  = 3'd0;
  localparam logic [2:0] REG_FADE_OUT_LEN = 3'd1;
  localparam logic [2:0] REG_CLIP_LEN     = 3'd2;
  localparam logic [2:0] REG_CURVE_MODE   = 3'd3;
  localparam logic [2:0] REG_CLIP_GAIN    = 3'd4;
  localparam logic [2:0] REG_CLIP_MUTED   = 3'd5;

  localparam logic [19:0] GAIN_RESET = 20'd65536;
  localparam logic [19:0] UNITY_LO   = 20'd65471;
  localparam logic [19:0] UNITY_HI   = 20'd65601;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  // how a word is handled by the back end
  localparam logic [1:0] KIND_MUTE = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_CALC = 2'd2;

  typedef struct packed {
    logic [31:0] fade_in_len;
    logic [31:0] fade_out_len;
    logic [31:0] clip_len;
    logic        curve_mode;
    logic [19:0] clip_gain;
    logic        clip_muted;
  } cfg_t;

  // sin(k*pi/(2*2^aw)) in Q1.16, Q30 Taylor series through x^9
  function automatic logic [16:0] sine_q16(input int unsigned k, input int unsigned aw);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    x    = (64'd1686629713 * 64'(k)) >> aw;
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    if (sum < 0) sum = 64'sd0;
    r = ($unsigned(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

endpackage

[design/cfge_queue.sv]
// Small register-based FIFO used between front and back and at the output.
// Depends on nothing.
module cfge_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_rd) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (!do_wr && do_rd) count <= count - 1'b1;
    end
  end
endmodule

[design/cfge_front.sv]
// Front end: classifies an incoming word (mute, bypass, fade) and forms
// the divider operands. Depends on cfge_pkg.
module cfge_front #(
  parameter int SAMPLE_BITS = 24,
  parameter int POS_BITS    = 32
) (
  input  cfge_pkg::cfg_t         cfg,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [POS_BITS-1:0]    clip_pos,
  output logic [SAMPLE_BITS+66:0] entry
);
  localparam int LW = ((POS_BITS > 32) ? POS_BITS : 32) + 1;

  logic [LW-1:0] pos_x;
  logic [LW-1:0] fi_x;
  logic [LW-1:0] fo_x;
  logic [LW-1:0] cl_x;
  logic [LW-1:0] rem_x;
  logic [31:0]   rem;
  logic          in_fi;
  logic          in_fo;
  logic          bypass;
  logic [1:0]    kind;
  logic          one;
  logic [31:0]   num;
  logic [31:0]   den;

  assign pos_x = LW'(clip_pos);
  assign fi_x  = LW'(cfg.fade_in_len);
  assign fo_x  = LW'(cfg.fade_out_len);
  assign cl_x  = LW'(cfg.clip_len);
  assign rem_x = (cl_x > pos_x) ? cl_x - pos_x : '0;
  assign rem   = rem_x[31:0];

  assign in_fi  = (cfg.fade_in_len != '0) && (pos_x < fi_x);
  assign in_fo  = (cfg.fade_out_len != '0) && (pos_x + fo_x >= cl_x);
  assign bypass = (cfg.fade_in_len == '0) && (cfg.fade_out_len == '0) &&
                  (cfg.clip_gain >= cfge_pkg::UNITY_LO) &&
                  (cfg.clip_gain <= cfge_pkg::UNITY_HI);

  always_comb begin
    kind = cfge_pkg::KIND_CALC;
    if (cfg.clip_muted) kind = cfge_pkg::KIND_MUTE;
    else if (bypass) kind = cfge_pkg::KIND_PASS;
    one = 1'b1;
    num = '0;
    den = cfg.fade_out_len;
    if (in_fi) begin
      // inside the fade-in the position is below a 32-bit length
      one = 1'b0;
      num = pos_x[31:0];
      den = cfg.fade_in_len;
    end else if (in_fo && (rem < cfg.fade_out_len)) begin
      // quotient below 1.0 only when the remainder is shorter than the fade
      one = 1'b0;
      num = rem;
    end
  end

  assign entry = {kind, sample, one, num, den};
endmodule

[design/cfge_back.sv]
// Back end: 16-stage restoring divider, sine interpolation, gain and
// sample multiplies, rounding and saturation. Depends on cfge_pkg.
module cfge_back #(
  parameter int SAMPLE_BITS      = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfge_pkg::cfg_t          cfg,
  input  logic [SAMPLE_BITS+66:0] entry,
  input  logic                    in_empty,
  output logic                    in_rd,
  input  logic                    out_full,
  output logic                    out_wr,
  output logic [SAMPLE_BITS-1:0]  out_word
);
  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int ND = 16;
  localparam logic signed [SB+4:0] SMAX = (SB+5)'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [SB+4:0] SMIN = -SMAX - 1;

  logic [16:0] tab [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    assign tab[k] = cfge_pkg::sine_q16(k, AW);
  end

  logic adv;

  // divider pipeline, stage 0 is the load
  logic          dv [ND+1];
  logic [1:0]    dk [ND+1];
  logic [SB-1:0] ds [ND+1];
  logic          d1 [ND+1];
  logic [31:0]   dr [ND+1];
  logic [31:0]   dd [ND+1];
  logic [15:0]   dq [ND+1];

  assign in_rd = adv && !in_empty;

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= in_rd;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      {dk[0], ds[0], d1[0], dr[0], dd[0]} <= entry;
      dq[0] <= '0;
    end
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    logic [32:0] t;
    logic        ge;
    assign t  = {dr[i], 1'b0};
    assign ge = (t >= {1'b0, dd[i]});
    always_ff @(posedge clk) begin
      if (rst) dv[i+1] <= 1'b0;
      else if (adv) dv[i+1] <= dv[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dk[i+1] <= dk[i];
        ds[i+1] <= ds[i];
        d1[i+1] <= d1[i];
        dd[i+1] <= dd[i];
        dr[i+1] <= ge ? 32'(t - {1'b0, dd[i]}) : t[31:0];
        dq[i+1] <= {dq[i][14:0], ge};
      end
    end
  end

  // stage A: fraction and table read
  logic [16:0] frac;
  logic [AW:0] idx;
  logic [AW:0] idx_b;
  logic        at_end;
  assign frac   = d1[ND] ? cfge_pkg::ONE_Q16 : {1'b0, dq[ND]};
  assign idx    = frac[16:16-AW];
  assign at_end = (idx >= (AW+1)'(SINE_TABLE_DEPTH));
  assign idx_b  = at_end ? (AW+1)'(SINE_TABLE_DEPTH) : idx + 1'b1;

  logic          av;
  logic [1:0]    ak;
  logic [SB-1:0] as_;
  logic [16:0]   afrac;
  logic [16:0]   aa;
  logic [16:0]   ab;
  logic [15:0]   af;

  always_ff @(posedge clk) begin
    if (rst) av <= 1'b0;
    else if (adv) av <= dv[ND];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ak    <= dk[ND];
      as_   <= ds[ND];
      afrac <= frac;
      aa    <= at_end ? tab[SINE_TABLE_DEPTH] : tab[idx];
      ab    <= tab[idx_b];
      af    <= 16'({frac[15-AW:0], {AW{1'b0}}});
    end
  end

  // stage B: interpolate
  logic [32:0] interp;
  logic [16:0] fade;
  assign interp = 33'(ab - aa) * 33'(af);
  assign fade   = !cfg.curve_mode ? afrac :
                  (ab <= aa) ? aa : aa + interp[32:16];

  logic          bv;
  logic [1:0]    bk;
  logic [SB-1:0] bs;
  logic [16:0]   bfade;
  always_ff @(posedge clk) begin
    if (rst) bv <= 1'b0;
    else if (adv) bv <= av;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      bk    <= ak;
      bs    <= as_;
      bfade <= fade;
    end
  end

  // stage C: gain times fade, rounded
  logic [37:0] gprod;
  assign gprod = 38'(cfg.clip_gain) * 38'(bfade) + 38'd32768;

  logic          cv;
  logic [1:0]    ck;
  logic [SB-1:0] cs;
  logic [19:0]   cgain;
  always_ff @(posedge clk) begin
    if (rst) cv <= 1'b0;
    else if (adv) cv <= bv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ck    <= bk;
      cs    <= bs;
      cgain <= gprod[35:16];
    end
  end

  // stage D: sample times gain
  logic signed [SB+20:0] sprod;
  assign sprod = (SB+21)'($signed(cs)) * $signed({1'b0, cgain}) + (SB+21)'(32768);

  logic                  ev;
  logic [1:0]            ek;
  logic [SB-1:0]         es;
  logic signed [SB+20:0] eprod;
  always_ff @(posedge clk) begin
    if (rst) ev <= 1'b0;
    else if (adv) ev <= cv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ek    <= ck;
      es    <= cs;
      eprod <= sprod;
    end
  end

  // stage E: floor shift, saturate, select by kind
  logic signed [SB+4:0] sh;
  logic [SB-1:0]        sat;
  logic [SB-1:0]        res;
  assign sh  = (SB+5)'(eprod >>> 16);
  assign sat = (sh > SMAX) ? SMAX[SB-1:0] : (sh < SMIN) ? SMIN[SB-1:0] : sh[SB-1:0];

  always_comb begin
    case (ek)
      cfge_pkg::KIND_MUTE: res = '0;
      cfge_pkg::KIND_PASS: res = es;
      default:             res = sat;
    endcase
  end

  logic          lv;
  logic [1:0]    lk;
  logic [SB-1:0] lres;
  always_ff @(posedge clk) begin
    if (rst) lv <= 1'b0;
    else if (adv) lv <= ev;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      lk   <= ek;
      lres <= res;
    end
  end

  assign adv      = !lv || !out_full;
  assign out_wr   = lv && !out_full;
  assign out_word = lres;

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> !out_full) else $error("write to full output queue");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (lv && out_full) |=> (lv && $stable(lres))) else $error("last stage lost on stall");
  a_mute_zero: assert property (@(posedge clk) disable iff (rst)
    (lv && lk == cfge_pkg::KIND_MUTE) |-> (lres == '0)) else $error("muted word not zero");
  a_pop_only_adv: assert property (@(posedge clk) disable iff (rst)
    in_rd |-> (adv && !in_empty)) else $error("queue read while stalled");
endmodule

[design/clip_fade_gain_envelope.sv]
// Clip fade/gain envelope: takes one sample word per clock when the input
// is not full and returns one word per sample, in order. A word passes
// through the input queue, 22 register stages in the back end (16 of them
// in the pipelined divider that forms the fade fraction), then the output
// queue. Throughput is one word per clock; the divider, both multipliers
// and the table stage are fully pipelined, and only a full output queue
// stalls the back end.
// Depends on cfge_pkg, cfge_front, cfge_queue and cfge_back.
module clip_fade_gain_envelope #(
  parameter int SAMPLE_BITS      = 24,
  parameter int POS_BITS         = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_idx,
  input  logic [31:0]            cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [POS_BITS-1:0]    clip_pos,
  output logic                   empty,
  input  logic                   pop,
  output logic [SAMPLE_BITS-1:0] out_sample
);
  localparam int EW = SAMPLE_BITS + 67;

  cfge_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_in_len  <= '0;
      cfg.fade_out_len <= '0;
      cfg.clip_len     <= '0;
      cfg.curve_mode   <= 1'b0;
      cfg.clip_gain    <= cfge_pkg::GAIN_RESET;
      cfg.clip_muted   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        cfge_pkg::REG_FADE_IN_LEN:  cfg.fade_in_len  <= cfg_data;
        cfge_pkg::REG_FADE_OUT_LEN: cfg.fade_out_len <= cfg_data;
        cfge_pkg::REG_CLIP_LEN:     cfg.clip_len     <= cfg_data;
        cfge_pkg::REG_CURVE_MODE:   cfg.curve_mode   <= cfg_data[0];
        cfge_pkg::REG_CLIP_GAIN:    cfg.clip_gain    <= cfg_data[19:0];
        cfge_pkg::REG_CLIP_MUTED:   cfg.clip_muted   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] f_entry;
  logic [EW-1:0] q_entry;
  logic          q_empty;
  logic          q_rd;
  logic          o_full;
  logic          o_wr;
  logic [SAMPLE_BITS-1:0] o_word;

  cfge_front #(.SAMPLE_BITS(SAMPLE_BITS), .POS_BITS(POS_BITS)) u_front (
    .cfg(cfg), .sample(sample), .clip_pos(clip_pos), .entry(f_entry)
  );

  cfge_queue #(.W(EW), .DEPTH(4)) u_midq (
    .clk(clk), .rst(rst), .wr(push), .wdata(f_entry), .full(full),
    .rd(q_rd), .rdata(q_entry), .empty(q_empty)
  );

  cfge_back #(.SAMPLE_BITS(SAMPLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .entry(q_entry), .in_empty(q_empty),
    .in_rd(q_rd), .out_full(o_full), .out_wr(o_wr), .out_word(o_word)
  );

  cfge_queue #(.W(SAMPLE_BITS), .DEPTH(4)) u_outq (
    .clk(clk), .rst(rst), .wr(o_wr), .wdata(o_word), .full(o_full),
    .rd(pop), .rdata(out_sample), .empty(empty)
  );
endmodule

[verif/tb_top.sv]
// Testbench for clip_fade_gain_envelope: directed table then random words,
// checked against an in-bench fade/gain predictor. Depends on cfge_pkg and clip_fade_gain_envelope.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [23:0] sample = '0;
  logic [31:0] clip_pos = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [23:0] out_sample;

  always #5 clk = ~clk;

  clip_fade_gain_envelope dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .push(push), .full(full), .sample(sample), .clip_pos(clip_pos),
    .empty(empty), .pop(pop), .out_sample(out_sample)
  );

  // predictor copy of the registers
  logic [31:0] m_fade_in, m_fade_out, m_clip_len;
  logic        m_curve, m_muted;
  logic [19:0] m_gain;
  logic [16:0] sine_rom [0:256];

  logic [23:0] expected_samples [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          pop_wait = 0;

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  task automatic queue_expected(input logic [23:0] w);
    expected_samples = {expected_samples, w};
  endtask

  function automatic logic [16:0] sine_interp(input logic [16:0] frac);
    logic [24:0] p;
    logic [8:0]  idx;
    logic [15:0] f;
    logic [16:0] a, b;
    p = 25'(frac) * 25'd256;
    idx = p[24:16];
    f = p[15:0];
    if (idx >= 9'd256) return sine_rom[256];
    a = sine_rom[idx];
    b = sine_rom[idx + 1];
    if (b <= a) return a;
    return a + 17'((34'(b - a) * 34'(f)) >> 16);
  endfunction

  function automatic logic [23:0] faded_sample(input logic [23:0] s_in,
                                               input logic [31:0] pos);
    logic [19:0] d;
    logic [16:0] frac, fade;
    logic [63:0] rem, q;
    logic [31:0] g;
    longint      r;
    if (m_muted) return '0;
    if (m_fade_in == 0 && m_fade_out == 0) begin
      d = (m_gain > 20'd65536) ? m_gain - 20'd65536 : 20'd65536 - m_gain;
      if (d <= 20'd65) return s_in;
    end
    frac = cfge_pkg::ONE_Q16;
    if (m_fade_in != 0 && pos < m_fade_in) begin
      frac = 17'(({32'd0, pos} << 16) / m_fade_in);
    end else if (m_fade_out != 0 && 64'(pos) + 64'(m_fade_out) >= 64'(m_clip_len)) begin
      rem = (m_clip_len > pos) ? 64'(m_clip_len - pos) : 64'd0;
      q = (rem << 16) / m_fade_out;
      frac = (q > 64'd65536) ? cfge_pkg::ONE_Q16 : 17'(q);
    end
    fade = m_curve ? sine_interp(frac) : frac;
    g = 32'((64'(m_gain) * 64'(fade) + 64'd32768) >> 16);
    r = longint'($signed(s_in)) * longint'(g) + 32768;
    r = r >>> 16;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return 24'(r);
  endfunction

  // leaves the write enable high; set_clip drops it after the last register
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      cfge_pkg::REG_FADE_IN_LEN:  m_fade_in  = val;
      cfge_pkg::REG_FADE_OUT_LEN: m_fade_out = val;
      cfge_pkg::REG_CLIP_LEN:     m_clip_len = val;
      cfge_pkg::REG_CURVE_MODE:   m_curve    = val[0];
      cfge_pkg::REG_CLIP_GAIN:    m_gain     = val[19:0];
      cfge_pkg::REG_CLIP_MUTED:   m_muted    = val[0];
      default: ;
    endcase
  endtask

  task automatic set_clip(input logic [31:0] fi, input logic [31:0] fo, input logic [31:0] cl,
                          input logic cm, input logic [19:0] g, input logic mu);
    write_reg(cfge_pkg::REG_FADE_IN_LEN, fi);
    write_reg(cfge_pkg::REG_FADE_OUT_LEN, fo);
    write_reg(cfge_pkg::REG_CLIP_LEN, cl);
    write_reg(cfge_pkg::REG_CURVE_MODE, {31'd0, cm});
    write_reg(cfge_pkg::REG_CLIP_GAIN, {12'd0, g});
    write_reg(cfge_pkg::REG_CLIP_MUTED, {31'd0, mu});
    cfg_we <= 1'b0;
  endtask

  // push one word; hold push high across back-to-back words
  task automatic send_word(input logic [23:0] s, input logic [31:0] pos,
                           input bit has_fixed, input logic [23:0] fixed_out);
    int gap;
    logic [23:0] want;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    sample   <= s;
    clip_pos <= pos;
    want = faded_sample(s, pos);
    if (has_fixed && want !== fixed_out) report_mismatch("table", want, fixed_out);
    queue_expected(has_fixed ? fixed_out : want);
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: a random wait before each word is taken
  always @(posedge clk) begin : pop_side
    int w;
    w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (rst) begin
      pop      <= 1'b0;
      pop_wait <= 0;
    end else if (pop && !empty) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected", out_sample, 'x);
      end else begin
        if (out_sample !== expected_samples[0])
          report_mismatch("out_sample", out_sample, expected_samples[0]);
        void'(expected_samples.pop_front());
      end
      if (w == 0) begin
        pop <= 1'b1;
      end else begin
        pop      <= 1'b0;
        pop_wait <= w;
      end
    end else if (pop_wait > 0) begin
      pop_wait <= pop_wait - 1;
      pop      <= (pop_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  typedef struct {
    logic [23:0] s;
    logic [31:0] pos;
    bit          fixed;
    logic [23:0] out;
  } row_t;

  row_t directed [] = '{
    '{24'h7FFFFF, 32'd0,          1, 24'h7FFFFF},
    '{24'h800000, 32'hFFFFFFFF,   1, 24'h800000},
    '{24'h000000, 32'd5,          1, 24'h000000},
    '{24'hFFFFFF, 32'd7,          1, 24'hFFFFFF},
    '{24'h123456, 32'h80000000,   1, 24'h123456}
  };

  row_t fade_rows [] = '{
    '{24'h7FFFFF, 32'd0,        1, 24'h000000},
    '{24'h7FFFFF, 32'd50,       0, 24'h0},
    '{24'h800000, 32'd99,       0, 24'h0},
    '{24'h7FFFFF, 32'd100,      0, 24'h0},
    '{24'h400000, 32'd950,      0, 24'h0},
    '{24'h800000, 32'd1000,     0, 24'h0},
    '{24'h7FFFFF, 32'hFFFFFFFF, 0, 24'h0},
    '{24'h000001, 32'd500,      0, 24'h0}
  };

  initial begin
    int i, phase, n, kind;
    logic [31:0] fi, fo, cl, pos;
    for (i = 0; i <= 256; i++) sine_rom[i] = cfge_pkg::sine_q16(i, 8);
    m_fade_in = 0; m_fade_out = 0; m_clip_len = 0;
    m_curve = 0; m_gain = cfge_pkg::GAIN_RESET; m_muted = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state is unity bypass
    foreach (directed[k]) send_word(directed[k].s, directed[k].pos, 1, directed[k].out);
    drain();

    // linear fades, fade-out runs past clip end
    set_clip(32'd100, 32'd100, 32'd1000, 1'b0, 20'hFFFFF, 1'b0);
    foreach (fade_rows[k]) send_word(fade_rows[k].s, fade_rows[k].pos, fade_rows[k].fixed,
                                     fade_rows[k].out);
    drain();
    // sine curve, fade-out longer than the clip
    set_clip(32'd0, 32'hFFFFFFFF, 32'd300, 1'b1, 20'd65536, 1'b0);
    foreach (fade_rows[k]) send_word(fade_rows[k].s, fade_rows[k].pos, 0, '0);
    drain();
    // muted, and zero gain
    set_clip(32'd0, 32'd0, 32'd0, 1'b0, 20'd65536, 1'b1);
    send_word(24'h7FFFFF, 32'd1, 1, 24'h000000);
    send_word(24'h800000, 32'd2, 1, 24'h000000);
    drain();
    set_clip(32'd0, 32'd0, 32'd0, 1'b0, 20'd0, 1'b0);
    send_word(24'h800000, 32'd3, 1, 24'h000000);
    send_word(24'h7FFFFF, 32'd4, 0, '0);
    drain();

    // random phases
    for (phase = 0; phase < 14; phase++) begin
      kind = $urandom_range(0, 3);
      fi = (kind == 0) ? $urandom() : $urandom_range(0, 2000);
      fo = (kind == 1) ? $urandom() : $urandom_range(0, 2000);
      cl = (kind == 2) ? $urandom() : $urandom_range(0, 5000);
      if ($urandom_range(0, 4) == 0) fi = 0;
      if ($urandom_range(0, 4) == 0) fo = 0;
      set_clip(fi, fo, cl, 1'($urandom_range(0, 1)),
               (phase % 4 == 0) ? 20'hFFFFF : (phase % 4 == 1) ? 20'(65536 + $urandom_range(0, 130) - 65)
                 : 20'($urandom()), $urandom_range(0, 9) == 0);
      for (n = 0; n < 50; n++) begin
        if ($urandom_range(0, 7) == 0) pos = $urandom();
        else pos = $urandom_range(0, cl > 6000 ? 6000 : cl + 100);
        send_word(24'($urandom()), pos, 0, '0);
      end
      drain();
    end

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
